/* design/i2c_master_transaction_engine_top_defines.svh */
// Assertion macros for the I2C transaction engine.
`ifndef I2C_MASTER_TRANSACTION_ENGINE_TOP_DEFINES_SVH
`define I2C_MASTER_TRANSACTION_ENGINE_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CHK_IMPL(label, clk, rst, ante, cons, msg)
`define CHK_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* design/i2cm_pkg.sv */
// Shared types and constants of the I2C transaction engine.
`default_nettype none
package i2cm_pkg;
  localparam int unsigned DEFAULT_MAX_BYTES = 255;
  localparam logic [15:0] BIT_WAIT_RESET = 16'd75;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_DATA  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ARB_LOST = 2'd1,
    ST_ADDR_NAK = 2'd2,
    ST_DATA_NAK = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0] op;
    logic [6:0] target_address;
    logic [7:0] byte_count;
    logic       restart_req;
    logic [7:0] write_data;
    logic       sda_in;
    logic       scl_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       busy_res;
    logic       want_data;
    logic [7:0] read_data;
    logic       read_valid;
    logic       done_res;
    logic [1:0] status;
  } out_item_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic       is_begin;
    logic       is_read;
    logic       is_data;
    logic [6:0] target_address;
    logic [7:0] byte_count;
    logic       restart_req;
    logic [7:0] write_data;
    logic       sda_in;
    logic       scl_in;
  } cmd_t;
endpackage
`default_nettype wire

/* design/i2cm_if.sv */
// Valid/ready channel interfaces for input and result items.
`default_nettype none
interface i2cm_in_if;
  logic valid;
  logic ready;
  i2cm_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cm_out_if;
  logic valid;
  logic ready;
  i2cm_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/i2cm_front.sv */
// Front end: accepts items, decodes the op and queues classified commands.
`default_nettype none
module i2cm_front (
  input  wire logic clk,
  input  wire logic rst,
  i2cm_in_if.sink   in_ch,
  output i2cm_pkg::cmd_t cmd,
  output logic      cmd_valid,
  input  wire logic cmd_ready
);
  import i2cm_pkg::*;

  // Two-entry queue between decode and the bus engine.
  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  cmd_t       dec;
  logic       push;
  logic       pop;

  always_comb begin
    dec.is_begin       = (in_ch.data.op == OP_WRITE) || (in_ch.data.op == OP_READ);
    dec.is_read        = (in_ch.data.op == OP_READ);
    dec.is_data        = (in_ch.data.op == OP_DATA);
    dec.target_address = in_ch.data.target_address;
    dec.byte_count     = in_ch.data.byte_count;
    dec.restart_req    = in_ch.data.restart_req;
    dec.write_data     = in_ch.data.write_data;
    dec.sda_in         = in_ch.data.sda_in;
    dec.scl_in         = in_ch.data.scl_in;
  end

  assign in_ch.ready = (fill != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign cmd_valid = (fill != 2'd0);
  assign pop = cmd_valid && cmd_ready;
  assign cmd = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

/* design/i2cm_back.sv */
// Back end: the bit-level bus engine and its result register.
`default_nettype none
module i2cm_back #(
  parameter int unsigned MAX_BYTES = i2cm_pkg::DEFAULT_MAX_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire i2cm_pkg::cmd_t cmd,
  input  wire logic        cmd_valid,
  output logic             cmd_ready,
  i2cm_out_if.source       out_ch
);
  import i2cm_pkg::*;

  localparam int unsigned BLW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES + 1) : 1;
  localparam int unsigned CLIPW = (BLW > 8) ? BLW : 8;

  typedef enum logic [4:0] {
    PH_IDLE = 5'd0, PH_A1 = 5'd1, PH_A2 = 5'd2, PH_A3 = 5'd3,
    PH_W1 = 5'd5, PH_W2 = 5'd6, PH_W3 = 5'd7,
    PH_R1 = 5'd9, PH_R2 = 5'd10, PH_R3 = 5'd11,
    PH_START = 5'd12, PH_WAITD = 5'd13, PH_STOP1 = 5'd14, PH_STOP2 = 5'd15,
    PH_STOP3 = 5'd16, PH_RS1 = 5'd17, PH_RS2 = 5'd18
  } phase_t;

  phase_t          phase, phase_next;
  logic [15:0]     bit_wait;
  logic [15:0]     tick_count, tick_next;
  logic [3:0]      bit_index, bit_next;
  logic [7:0]      shift_byte, shift_next;
  logic [BLW-1:0]  bytes_left, bytes_next;
  logic            is_read, is_read_next;
  logic            restart, restart_next;
  logic [1:0]      code, code_next;
  logic            scl_low, scl_next;
  logic            sda_low, sda_next;
  logic [7:0]      rdata;
  logic            rvalid, done;
  logic [15:0]     tick_inc;
  logic [15:0]     half;
  logic            step;
  logic            sbit;
  logic [CLIPW-1:0] cnt_wide;
  logic [BLW-1:0]  cnt_clip;

  assign tick_inc = tick_count + 16'd1;
  assign half = {1'b0, bit_wait[15:1]};
  assign cmd_ready = !out_ch.valid || out_ch.ready;
  assign step = cmd_valid && cmd_ready;
  assign cnt_wide = CLIPW'(cmd.byte_count);
  assign cnt_clip = (cnt_wide > CLIPW'(MAX_BYTES)) ? BLW'(MAX_BYTES) : BLW'(cnt_wide);

  always_comb begin
    unique case (phase)
      PH_R1, PH_R2, PH_R3: sbit = (bit_index < 4'd8) ? 1'b1 : !(bytes_left > BLW'(1));
      default:             sbit = (bit_index < 4'd8) ? shift_byte[7] : 1'b1;
    endcase
  end

  // Closing sequence after a transaction: stop, or repeated-start preparation.
  function automatic phase_t end_phase(input logic [1:0] c, input logic rs);
    end_phase = (c == ST_OK && rs) ? PH_RS1 : PH_STOP1;
  endfunction

  always_comb begin
    phase_next = phase; tick_next = tick_count; bit_next = bit_index;
    shift_next = shift_byte; bytes_next = bytes_left; is_read_next = is_read;
    restart_next = restart; code_next = code; scl_next = scl_low; sda_next = sda_low;
    rdata = 8'd0; rvalid = 1'b0; done = 1'b0;
    unique case (phase)
      PH_A1, PH_W1, PH_R1: begin
        scl_next = 1'b1;
        sda_next = !sbit;
        tick_next = tick_inc;
        if (tick_inc >= bit_wait) phase_next = phase_t'(phase + 5'd1);
      end
      PH_A2, PH_W2, PH_R2: begin
        scl_next = 1'b0;
        if (cmd.scl_in) begin
          if (bit_index < 4'd8) begin
            if (phase != PH_R2 && cmd.sda_in != shift_byte[7]) begin
              sda_next = 1'b0; code_next = ST_ARB_LOST; done = 1'b1;
              phase_next = PH_IDLE; tick_next = '0;
            end else begin
              shift_next = {shift_byte[6:0], cmd.sda_in};
            end
          end else if (phase != PH_R2) begin
            shift_next = {7'd0, cmd.sda_in};
          end
          if (!done) begin
            phase_next = phase_t'(phase + 5'd1); tick_next = '0;
          end
        end
      end
      PH_A3, PH_W3, PH_R3: begin
        if (cmd.scl_in && tick_count < half) begin
          tick_next = tick_inc;
        end else if (bit_index < 4'd8) begin
          bit_next = bit_index + 4'd1; tick_next = '0;
          phase_next = phase_t'(phase - 5'd2);
        end else begin
          bit_next = '0; tick_next = '0;
          if (phase == PH_A3) begin
            if (shift_byte[0]) begin
              code_next = ST_ADDR_NAK; phase_next = PH_STOP1;
            end else if (bytes_left == '0) begin
              code_next = ST_OK; phase_next = end_phase(ST_OK, restart);
            end else if (is_read) begin
              shift_next = '0; phase_next = PH_R1;
            end else begin
              phase_next = PH_WAITD;
            end
          end else if (phase == PH_W3) begin
            if (shift_byte[0]) begin
              code_next = ST_DATA_NAK; phase_next = PH_STOP1;
            end else begin
              bytes_next = bytes_left - BLW'(1);
              if (bytes_left == BLW'(1)) begin
                code_next = ST_OK; phase_next = end_phase(ST_OK, restart);
              end else begin
                phase_next = PH_WAITD;
              end
            end
          end else begin
            rvalid = 1'b1; rdata = shift_byte;
            bytes_next = bytes_left - BLW'(1);
            if (bytes_left == BLW'(1)) begin
              code_next = ST_OK; phase_next = end_phase(ST_OK, restart);
            end else begin
              shift_next = '0; phase_next = PH_R1;
            end
          end
        end
      end
      PH_IDLE: begin
        scl_next = 1'b0; sda_next = 1'b0;
        if (cmd.is_begin) begin
          is_read_next = cmd.is_read; restart_next = cmd.restart_req;
          bytes_next = cnt_clip;
          shift_next = {cmd.target_address, cmd.is_read};
          bit_next = '0; code_next = ST_OK; tick_next = '0;
          sda_next = 1'b1; phase_next = PH_START;
        end
      end
      PH_START: begin
        scl_next = 1'b0; sda_next = 1'b1; tick_next = tick_inc;
        if (tick_inc >= bit_wait) begin
          scl_next = 1'b1; tick_next = '0; phase_next = PH_A1;
        end
      end
      PH_WAITD: begin
        scl_next = 1'b1; sda_next = 1'b0;
        if (cmd.is_data) begin
          shift_next = cmd.write_data; bit_next = '0; tick_next = '0;
          phase_next = PH_W1;
        end
      end
      PH_STOP1: begin
        scl_next = 1'b1; sda_next = 1'b1; tick_next = tick_inc;
        if (tick_inc >= bit_wait) begin tick_next = '0; phase_next = PH_STOP2; end
      end
      PH_STOP2: begin
        scl_next = 1'b0; sda_next = 1'b1; tick_next = tick_inc;
        if (tick_inc >= bit_wait) begin tick_next = '0; phase_next = PH_STOP3; end
      end
      PH_STOP3: begin
        scl_next = 1'b0; sda_next = 1'b0; done = 1'b1;
        phase_next = PH_IDLE; tick_next = '0;
      end
      PH_RS1: begin
        scl_next = 1'b1; sda_next = 1'b0; tick_next = tick_inc;
        if (tick_inc >= bit_wait) begin tick_next = '0; phase_next = PH_RS2; end
      end
      PH_RS2: begin
        scl_next = 1'b0; sda_next = 1'b0; tick_next = tick_inc;
        if (tick_inc >= bit_wait) begin
          done = 1'b1; phase_next = PH_IDLE; tick_next = '0;
        end
      end
      default: begin
        scl_next = 1'b0; sda_next = 1'b0; phase_next = PH_IDLE; tick_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_wait <= BIT_WAIT_RESET;
      phase <= PH_IDLE; tick_count <= '0; bit_index <= '0; shift_byte <= '0;
      bytes_left <= '0; is_read <= 1'b0; restart <= 1'b0; code <= ST_OK;
      scl_low <= 1'b0; sda_low <= 1'b0; out_ch.valid <= 1'b0;
    end else begin
      if (cfg_we) bit_wait <= cfg_wdata;
      if (step) begin
        phase <= phase_next; tick_count <= tick_next; bit_index <= bit_next;
        shift_byte <= shift_next; bytes_left <= bytes_next;
        is_read <= is_read_next; restart <= restart_next; code <= code_next;
        scl_low <= scl_next; sda_low <= sda_next;
        out_ch.valid <= 1'b1;
        out_ch.data.scl_drive_low <= scl_next;
        out_ch.data.sda_drive_low <= sda_next;
        out_ch.data.busy_res <= (phase_next != PH_IDLE);
        out_ch.data.want_data <= (phase_next == PH_WAITD);
        out_ch.data.read_data <= rdata;
        out_ch.data.read_valid <= rvalid;
        out_ch.data.done_res <= done;
        out_ch.data.status <= done ? code_next : ST_OK;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

/* design/i2c_master_transaction_engine_top.sv */
// Top level of the I2C transaction engine: front decode, queue and bus engine.
//   channel  dir  payload
//   in_ch    in   op, address, count, restart flag, write byte, sampled lines
//   out_ch   out  line drives, busy, want_data, read byte, done, status
//   cfg      in   bit_wait_ticks write
// One item per cycle while the queue is not full: each accepted item is one bus
// tick. The engine registers its result on the edge that takes the item from the
// two-entry queue.
// Reset is synchronous and leaves both bus lines released and the engine idle.
// A stalled output holds the engine; the queue keeps taking items until full.
`default_nettype none
`include "i2c_master_transaction_engine_top_defines.svh"
module i2c_master_transaction_engine_top #(
  parameter int unsigned MAX_BYTES = i2cm_pkg::DEFAULT_MAX_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  i2cm_in_if.sink          in_ch,
  i2cm_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  import i2cm_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  i2cm_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready)
  );

  i2cm_back #(.MAX_BYTES(MAX_BYTES)) u_back (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .out_ch(out_ch)
  );

  `CHK_IMPL(a_status_only_done, clk, rst, out_ch.valid && !out_ch.data.done_res, out_ch.data.status == ST_OK, "status without done")
  `CHK_IMPL(a_want_busy, clk, rst, out_ch.valid && out_ch.data.want_data, out_ch.data.busy_res, "want_data while idle")
  `CHK_NEXT(a_step_result, clk, rst, cmd_valid && cmd_ready, out_ch.valid, "command without result")
endmodule
`default_nettype wire
